// ===== sv/bpc_pkg.sv =====
// Shared types, constants and the green test for the ball pixel classifier.
package bpc_pkg;

    localparam int CHAN_W       = 8;
    localparam int TABLE_ADDR_W = 3 * CHAN_W;
    localparam int CFG_W        = 11;
    localparam int COL_W        = 10;
    localparam int GSUM_W       = 13;

    localparam logic [CFG_W-1:0]  ROW_WIDTH_RESET = 11'd640;
    localparam logic [GSUM_W-1:0] GREEN_SUM_MIN   = 13'd200;
    localparam logic [GSUM_W-1:0] GREEN_SUM_MAX   = 13'd600;

    typedef enum logic [1:0] {
        CMD_TABLE_WR = 2'd0,
        CMD_PIXEL    = 2'd1,
        CMD_FLUSH    = 2'd2,
        CMD_RSVD     = 2'd3
    } cmd_t;

    // Field green: channel sum in range and all ratio windows met, exact
    // by cross-multiplication with small constants.
    function automatic logic bpc_is_green(input logic [CHAN_W-1:0] b,
                                          input logic [CHAN_W-1:0] g,
                                          input logic [CHAN_W-1:0] r);
        logic [GSUM_W-1:0] bx;
        logic [GSUM_W-1:0] gx;
        logic [GSUM_W-1:0] rx;
        logic [GSUM_W-1:0] s;
        logic              ok_sum;
        logic              ok_g;
        logic              ok_r;
        logic              ok_b;
        bx     = GSUM_W'(b);
        gx     = GSUM_W'(g);
        rx     = GSUM_W'(r);
        s      = bx + gx + rx;
        ok_sum = (s >= GREEN_SUM_MIN) && (s <= GREEN_SUM_MAX);
        ok_g   = (GSUM_W'(5) * gx > GSUM_W'(2) * s) && (GSUM_W'(2) * gx < s);
        ok_r   = (GSUM_W'(20) * rx > GSUM_W'(3) * s) && (GSUM_W'(4) * rx < s);
        ok_b   = (GSUM_W'(4) * bx > s) && (GSUM_W'(20) * bx < GSUM_W'(7) * s);
        return ok_sum && ok_g && ok_r && ok_b;
    endfunction

endpackage

// ===== sv/bpc_color_table.sv =====
// Ball colour lookup table: one bit per 24-bit colour, one write and one read port.
module bpc_color_table
    import bpc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    wr_en,
    input  logic [TABLE_ADDR_W-1:0] wr_addr,
    input  logic                    wr_data,
    input  logic                    rd_en,
    input  logic [TABLE_ADDR_W-1:0] rd_addr,
    output logic                    rd_data
);

    localparam int DEPTH = 1 << TABLE_ADDR_W;

    logic mem [0:DEPTH-1];
    logic rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/bpc_mark_buffer.sv =====
// Two-row ball mark buffer with write-to-read forwarding.
module bpc_mark_buffer
    import bpc_pkg::*;
#(
    parameter int ADDR_W = 11
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic              wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic              rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic mem [0:DEPTH-1];
    logic q_reg;
    logic fwd_reg;
    logic fwd_next;
    logic fwd_data_reg;

    // Take the word being written when it lands on the entry being read.
    assign fwd_next = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            q_reg        <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_reg <= fwd_next;
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : q_reg;

endmodule

// ===== sv/ball_pixel_on_field_classifier_top.sv =====
// Top level of the ball pixel on field classifier.
//
// Classifies a BGR pixel stream row by row. A table write, a pixel or a flush
// is accepted each clock while the result side keeps up, and a verdict passes
// through the stage-one register and then the output register. The rate is set
// by the single read port of the colour table and of the row mark buffer, each
// read at most once per transfer. A pixel is a ball pixel when the
// colour table marks its colour and its own row holds a field-green pixel
// strictly left and strictly right of it; verdicts of row n come out while row
// n+1 streams in, one per transfer, in column order, with row_end on the last
// column. Flush transfers drain the last row; a row closed by flushes is
// dropped. Command 3 is ignored. The colour table (2^24 x 1) and the mark
// buffer (two rows) are not cleared at reset: load every colour a pixel may
// carry before sending it. row_width (clamped to 1..MAX_WIDTH) may change only
// while the block is idle.
module ball_pixel_on_field_classifier_top
    import bpc_pkg::*;
#(
    parameter int MAX_WIDTH    = 1024,
    parameter int CHANNEL_BITS = 8
)
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // configuration
    input  logic                    cfg_wr_en,
    input  logic [CFG_W-1:0]        cfg_wr_data,
    // input channel
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_cmd,
    input  logic [TABLE_ADDR_W-1:0] s_table_index,
    input  logic                    s_table_flag,
    input  logic [CHAN_W-1:0]       s_blue,
    input  logic [CHAN_W-1:0]       s_green,
    input  logic [CHAN_W-1:0]       s_red,
    // result channel
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_ball_pixel,
    output logic [COL_W-1:0]        m_column,
    output logic                    m_row_end
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WW     = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int MARK_W = CW + 1;
    localparam logic [CHAN_W-1:0] CHAN_MASK = CHAN_W'((1 << CHANNEL_BITS) - 1);

    // Stage-one control: the item whose memory reads are in flight.
    typedef struct packed {
        logic valid;
        logic emit;
        logic pixel;
        logic ball_cond;
        logic row_end;
    } s1_ctl_t;

    // ---------------------------------------------------------------
    // Configuration and row geometry
    // ---------------------------------------------------------------
    logic [CFG_W-1:0] row_width_reg;
    logic [WW-1:0]    rw_ext;
    logic [CW-1:0]    last_col;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= ROW_WIDTH_RESET;
        end else if (cfg_wr_en) begin
            row_width_reg <= cfg_wr_data;
        end
    end

    // Clamp the row width to 1..MAX_WIDTH and keep its last column index.
    assign rw_ext = WW'(row_width_reg);

    always_comb begin
        if (rw_ext == '0) begin
            last_col = '0;
        end else if (rw_ext > WW'(MAX_WIDTH)) begin
            last_col = CW'(MAX_WIDTH - 1);
        end else begin
            last_col = CW'(rw_ext - WW'(1));
        end
    end

    // ---------------------------------------------------------------
    // Row tracking state
    // ---------------------------------------------------------------
    logic [CW-1:0] col_reg, col_next;
    logic          cur_row_reg, cur_row_next;
    logic          prev_valid_reg, prev_valid_next;
    logic [1:0]    green_seen_reg, green_seen_next;
    logic [CW-1:0] first_green_reg [2];
    logic [CW-1:0] first_green_next [2];
    logic [CW-1:0] last_green_reg [2];
    logic [CW-1:0] last_green_next [2];

    logic          accept;
    logic          is_pix;
    logic          is_flush;
    logic          step;
    logic          row_close;
    logic          prev_row;
    logic          ball_cond;
    logic          pix_green;
    logic [CHAN_W-1:0] b_m, g_m, r_m;

    s1_ctl_t           s1_reg, s1_next;
    logic [MARK_W-1:0] s1_addr_reg;
    logic [CW-1:0]     s1_col_reg;
    logic              s1_adv;

    logic              tbl_rd_data;
    logic              mark_rd_data;
    logic              mark_wr_en;

    logic              m_valid_reg;
    logic              m_ball_pixel_reg;
    logic [COL_W-1:0]  m_column_reg;
    logic              m_row_end_reg;

    // Stage one leaves when it has no verdict or the output register frees.
    assign s1_adv  = !s1_reg.valid || !s1_reg.emit || !m_valid_reg || m_ready;
    assign s_ready = s1_adv;
    assign accept  = s_valid && s_ready;

    assign is_pix   = (s_cmd == CMD_PIXEL);
    assign is_flush = (s_cmd == CMD_FLUSH);
    assign step     = accept && (is_pix || (is_flush && prev_valid_reg));

    assign b_m = s_blue  & CHAN_MASK;
    assign g_m = s_green & CHAN_MASK;
    assign r_m = s_red   & CHAN_MASK;

    assign pix_green = bpc_is_green(b_m, g_m, r_m);
    assign row_close = (col_reg >= last_col);
    assign prev_row  = ~cur_row_reg;

    // Green bounds of the previous row are settled; judge them up front.
    assign ball_cond = green_seen_reg[prev_row]
                    && (first_green_reg[prev_row] < col_reg)
                    && (last_green_reg[prev_row] > col_reg);

    always_comb begin
        col_next         = col_reg;
        cur_row_next     = cur_row_reg;
        prev_valid_next  = prev_valid_reg;
        green_seen_next  = green_seen_reg;
        first_green_next = first_green_reg;
        last_green_next  = last_green_reg;
        if (step) begin
            // Widen the current row's green span.
            if (is_pix && pix_green) begin
                if (!green_seen_reg[cur_row_reg]) begin
                    first_green_next[cur_row_reg] = col_reg;
                end
                last_green_next[cur_row_reg] = col_reg;
                green_seen_next[cur_row_reg] = 1'b1;
            end
            // Close the row: swap buffers, restart the column.
            if (row_close) begin
                cur_row_next              = prev_row;
                green_seen_next[prev_row] = 1'b0;
                prev_valid_next           = is_pix;
                col_next                  = '0;
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            cur_row_reg    <= 1'b0;
            prev_valid_reg <= 1'b0;
            green_seen_reg <= '0;
        end else begin
            col_reg        <= col_next;
            cur_row_reg    <= cur_row_next;
            prev_valid_reg <= prev_valid_next;
            green_seen_reg <= green_seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        first_green_reg <= first_green_next;
        last_green_reg  <= last_green_next;
    end

    // ---------------------------------------------------------------
    // Memories
    // ---------------------------------------------------------------
    bpc_color_table u_color_table (
        .aclk    (aclk),
        .wr_en   (accept && (s_cmd == CMD_TABLE_WR)),
        .wr_addr (s_table_index),
        .wr_data (s_table_flag),
        .rd_en   (accept && is_pix),
        .rd_addr ({r_m, g_m, b_m}),
        .rd_data (tbl_rd_data)
    );

    // Write the mark as the item leaves stage one; flushes store no ball.
    assign mark_wr_en = s1_reg.valid && s1_adv;

    bpc_mark_buffer #(
        .ADDR_W (MARK_W)
    ) u_mark_buffer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (mark_wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_reg.pixel && tbl_rd_data),
        .rd_en   (step),
        .rd_addr ({prev_row, col_reg}),
        .rd_data (mark_rd_data)
    );

    // ---------------------------------------------------------------
    // Stage one: hold the item while its reads complete
    // ---------------------------------------------------------------
    always_comb begin
        s1_next = s1_reg;
        if (s1_adv) begin
            s1_next.valid     = step;
            s1_next.emit      = prev_valid_reg;
            s1_next.pixel     = is_pix;
            s1_next.ball_cond = ball_cond;
            s1_next.row_end   = row_close;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg <= '0;
        end else begin
            s1_reg <= s1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            s1_addr_reg <= {cur_row_reg, col_reg};
            s1_col_reg  <= col_reg;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_reg.valid && s1_reg.emit && s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_reg.valid && s1_reg.emit && s1_adv) begin
            m_ball_pixel_reg <= s1_reg.ball_cond && mark_rd_data;
            m_column_reg     <= COL_W'(s1_col_reg);
            m_row_end_reg    <= s1_reg.row_end;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_ball_pixel = m_ball_pixel_reg;
    assign m_column     = m_column_reg;
    assign m_row_end    = m_row_end_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // Input stalls only behind a verdict that waits on a full output.
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && s1_reg.valid && s1_reg.emit))
        else $error("input stalled without output back-pressure");

    // A flush with no pending row leaves the column alone.
    a_flush_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_flush && !prev_valid_reg) |=> $stable(col_reg))
        else $error("idle flush moved the column");

    // The row buffers swap only as the column restarts.
    a_row_swap: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && row_close) |=> ((cur_row_reg != $past(cur_row_reg)) && (col_reg == '0)))
        else $error("row close did not swap buffers");

endmodule

// ===== tb/ball_verdict_checker.sv =====
// Checker that predicts and compares the ball pixel verdict stream.
module ball_verdict_checker
    import bpc_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_W-1:0]        cfg_wr_data,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic [1:0]              s_cmd,
    input  logic [TABLE_ADDR_W-1:0] s_table_index,
    input  logic                    s_table_flag,
    input  logic [CHAN_W-1:0]       s_blue,
    input  logic [CHAN_W-1:0]       s_green,
    input  logic [CHAN_W-1:0]       s_red,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic                    m_ball_pixel,
    input  logic [COL_W-1:0]        m_column,
    input  logic                    m_row_end,
    output int                      verdict_errors,
    output int                      verdicts_owed
);

    typedef struct packed {
        logic             ball;
        logic [COL_W-1:0] column;
        logic             row_end;
    } verdict_t;

    verdict_t owed_q[$];
    verdict_t head;

    // Own copy of the classifier state.
    bit                    ball_lut [bit [TABLE_ADDR_W-1:0]];
    bit                    row_marks [2][MAX_WIDTH];
    bit [CFG_W-1:0]        first_green [2];
    bit [CFG_W-1:0]        last_green [2];
    bit                    green_hit [2];
    int unsigned           col_pos;
    bit                    prev_row_ready;
    bit                    fill_buf;
    bit [CFG_W-1:0]        width_cfg;

    function automatic bit field_green(bit [CHAN_W-1:0] b, bit [CHAN_W-1:0] g,
                                       bit [CHAN_W-1:0] r);
        int unsigned bb;
        int unsigned gg;
        int unsigned rr;
        int unsigned sum;
        bb  = 32'(b);
        gg  = 32'(g);
        rr  = 32'(r);
        sum = bb + gg + rr;
        if (sum < 200 || sum > 600) return 1'b0;
        return (5 * gg > 2 * sum) && (2 * gg < sum) &&
               (20 * rr > 3 * sum) && (4 * rr < sum) &&
               (4 * bb > sum) && (20 * bb < 7 * sum);
    endfunction

    function automatic int unsigned active_width();
        if (width_cfg == 0) return 1;
        if (width_cfg > MAX_WIDTH) return MAX_WIDTH;
        return 32'(width_cfg);
    endfunction

    // Advance the model by one accepted transfer; queue the verdict it owes.
    task automatic classify_transfer(cmd_t cmd, bit [TABLE_ADDR_W-1:0] idx, bit flag,
                                     bit [CHAN_W-1:0] b, bit [CHAN_W-1:0] g,
                                     bit [CHAN_W-1:0] r);
        int unsigned           w;
        int unsigned           c;
        bit                    pixel;
        bit                    prior;
        verdict_t              v;
        bit [TABLE_ADDR_W-1:0] key;
        if (cmd == CMD_TABLE_WR) begin
            ball_lut[idx] = flag;
            return;
        end
        if (cmd == CMD_RSVD) return;
        if (cmd == CMD_FLUSH && !prev_row_ready) return;
        pixel = (cmd == CMD_PIXEL);
        w     = active_width();
        c     = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
        prior = !fill_buf;
        if (prev_row_ready) begin
            v.ball    = row_marks[prior][c] && green_hit[prior] &&
                        (first_green[prior] < c) && (last_green[prior] > c);
            v.column  = c[COL_W-1:0];
            v.row_end = (c + 1 >= w);
            owed_q.push_back(v);
        end
        if (pixel) begin
            key = {r, g, b};
            row_marks[fill_buf][c] = ball_lut.exists(key) ? ball_lut[key] : 1'b0;
            if (field_green(b, g, r)) begin
                if (!green_hit[fill_buf]) first_green[fill_buf] = c[CFG_W-1:0];
                last_green[fill_buf] = c[CFG_W-1:0];
                green_hit[fill_buf]  = 1'b1;
            end
        end else begin
            row_marks[fill_buf][c] = 1'b0;
        end
        if (c + 1 >= w) begin
            fill_buf              = !fill_buf;
            green_hit[fill_buf]   = 1'b0;
            first_green[fill_buf] = '0;
            last_green[fill_buf]  = '0;
            prev_row_ready        = pixel;
            col_pos               = 0;
        end else begin
            col_pos = c + 1;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            owed_q.delete();
            green_hit      = '{1'b0, 1'b0};
            first_green    = '{'0, '0};
            last_green     = '{'0, '0};
            col_pos        = 0;
            prev_row_ready = 1'b0;
            fill_buf       = 1'b0;
            width_cfg      = ROW_WIDTH_RESET;
            verdict_errors = 0;
        end else begin
            if (cfg_wr_en) width_cfg = cfg_wr_data;
            if (s_valid && s_ready)
                classify_transfer(cmd_t'(s_cmd), s_table_index, s_table_flag,
                                  s_blue, s_green, s_red);
            if (m_valid && m_ready) begin
                if (owed_q.size() == 0) begin
                    $error("unexpected verdict: column %0d ball_pixel %0d", m_column,
                           m_ball_pixel);
                    verdict_errors++;
                end else begin
                    head = owed_q.pop_front();
                    if (m_ball_pixel !== head.ball) begin
                        $error("ball_pixel: expected %0d, actual %0d", head.ball,
                               m_ball_pixel);
                        verdict_errors++;
                    end
                    if (m_column !== head.column) begin
                        $error("column: expected %0d, actual %0d", head.column, m_column);
                        verdict_errors++;
                    end
                    if (m_row_end !== head.row_end) begin
                        $error("row_end: expected %0d, actual %0d", head.row_end, m_row_end);
                        verdict_errors++;
                    end
                end
            end
        end
        verdicts_owed = owed_q.size();
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the ball pixel classifier regression: stimulus, idling and verdict.
module testbench;
    import bpc_pkg::*;

    localparam int MAX_W           = 1024;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int PALETTE_MAX     = 48;

    // Colours at the edges of the green test: the near ones miss only on the sum.
    localparam bit [23:0] BLACK      = 24'h000000;
    localparam bit [23:0] WHITE      = 24'hFFFFFF;
    localparam bit [23:0] GREEN_LOW  = {8'd44, 8'd90, 8'd66};    // sum 200
    localparam bit [23:0] NEAR_LOW   = {8'd44, 8'd90, 8'd65};    // sum 199
    localparam bit [23:0] GREEN_HIGH = {8'd140, 8'd255, 8'd205}; // sum 600
    localparam bit [23:0] NEAR_HIGH  = {8'd140, 8'd255, 8'd206}; // sum 601

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CFG_W-1:0]        cfg_wr_data;
    logic                    s_valid;
    logic                    s_ready;
    logic [1:0]              s_cmd;
    logic [TABLE_ADDR_W-1:0] s_table_index;
    logic                    s_table_flag;
    logic [CHAN_W-1:0]       s_blue;
    logic [CHAN_W-1:0]       s_green;
    logic [CHAN_W-1:0]       s_red;
    logic                    m_valid;
    logic                    m_ready;
    logic                    m_ball_pixel;
    logic [COL_W-1:0]        m_column;
    logic                    m_row_end;

    int verdict_errors;
    int verdicts_owed;

    // Idling knobs, in percent of cycles, changed per phase.
    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    bit hold_req      = 1'b0;

    // Stimulus bookkeeping: where the block is in its row, so that rows can
    // be drained before a width change and pixels only use loaded colours.
    int unsigned stim_width       = 32'(ROW_WIDTH_RESET);
    int unsigned stim_col         = 0;
    bit          stim_row_pending = 1'b0;
    bit [23:0]   palette[$];

    int quiet_cycles = 0;

    ball_pixel_on_field_classifier_top #(
        .MAX_WIDTH    (MAX_W),
        .CHANNEL_BITS (CHAN_W)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_table_index (s_table_index),
        .s_table_flag  (s_table_flag),
        .s_blue        (s_blue),
        .s_green       (s_green),
        .s_red         (s_red),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ball_pixel  (m_ball_pixel),
        .m_column      (m_column),
        .m_row_end     (m_row_end)
    );

    ball_verdict_checker #(
        .MAX_WIDTH (MAX_W)
    ) u_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_table_index  (s_table_index),
        .s_table_flag   (s_table_flag),
        .s_blue         (s_blue),
        .s_green        (s_green),
        .s_red          (s_red),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_ball_pixel   (m_ball_pixel),
        .m_column       (m_column),
        .m_row_end      (m_row_end),
        .verdict_errors (verdict_errors),
        .verdicts_owed  (verdicts_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Receiver: stall at the phase's rate; on request hold off for a long
    // stretch so the block backs up into its input.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_left = HOLD_OFF_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    // Watchdog: end the run when no transfer happens on either channel for
    // far longer than the longest hold-off.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("Regression FAIL");
                    $finish;
                end
            end
        end
    end

    // Offer one item: idle first at the phase's rate, then hold valid and the
    // payload until the transfer, then advance the row bookkeeping.
    task automatic send_item(cmd_t cmd, bit [23:0] idx, bit flag, bit [23:0] colour);
        int          gap;
        int unsigned c;
        gap = 0;
        while ($urandom_range(99) < snd_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= cmd;
        s_table_index <= idx;
        s_table_flag  <= flag;
        s_blue        <= colour[7:0];
        s_green       <= colour[15:8];
        s_red         <= colour[23:16];
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (cmd == CMD_PIXEL || (cmd == CMD_FLUSH && stim_row_pending)) begin
            c = (stim_col >= MAX_W) ? MAX_W - 1 : stim_col;
            if (c + 1 >= stim_width) begin
                stim_row_pending = (cmd == CMD_PIXEL);
                stim_col         = 0;
            end else begin
                stim_col = c + 1;
            end
        end
    endtask

    // Unused fields of every item these tasks send carry random noise.
    task automatic send_pixel(bit [23:0] colour);
        bit [31:0] noise;
        noise = $urandom();
        send_item(CMD_PIXEL, noise[23:0], noise[24], colour);
    endtask

    task automatic send_flush();
        bit [31:0] noise;
        bit [31:0] chan;
        noise = $urandom();
        chan  = $urandom();
        send_item(CMD_FLUSH, noise[23:0], noise[24], chan[23:0]);
    endtask

    task automatic send_table_write(bit [23:0] colour, bit flag);
        bit [31:0] chan;
        chan = $urandom();
        send_item(CMD_TABLE_WR, colour, flag, chan[23:0]);
    endtask

    // Colour near the middle of every green ratio window; some land just
    // outside a window, which is welcome too.
    function automatic bit [23:0] greenish_colour();
        int sum;
        int g;
        int r;
        int b;
        sum = $urandom_range(520, 210);
        g   = sum * 47 / 100 + int'($urandom_range(sum / 25)) - sum / 50;
        r   = sum * 22 / 100 + int'($urandom_range(sum / 25)) - sum / 50;
        b   = sum - g - r;
        return {8'(r), 8'(g), 8'(b)};
    endfunction

    task automatic send_random_item();
        int        pick;
        bit [31:0] noise;
        bit [31:0] chan;
        bit [23:0] colour;
        bit        fresh;
        pick  = $urandom_range(99);
        noise = $urandom();
        chan  = $urandom();
        if (pick < 78) begin
            send_pixel(palette[$urandom_range(palette.size() - 1)]);
        end else if (pick < 86) begin
            // Rewrite a loaded colour's flag, or load a new colour.
            fresh  = noise[31];
            colour = fresh ? (noise[30] ? greenish_colour() : chan[23:0])
                           : palette[$urandom_range(palette.size() - 1)];
            send_table_write(colour, noise[0]);
            if (fresh && palette.size() < PALETTE_MAX) palette.push_back(colour);
        end else if (pick < 95) begin
            send_flush();
        end else begin
            send_item(CMD_RSVD, noise[23:0], noise[24], chan[23:0]);
        end
    endtask

    // Flush until the pending row has been emitted and dropped.
    task automatic drain_pending_row();
        while (stim_row_pending) send_flush();
    endtask

    // Drop valid, wait until every owed verdict has arrived, then give the
    // pipeline time to finish any item that owes nothing.
    task automatic settle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (verdicts_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_row_width(int unsigned width);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= width[CFG_W-1:0];
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        stim_width = (width[CFG_W-1:0] == 0) ? 1 :
                     (width[CFG_W-1:0] > MAX_W) ? MAX_W : 32'(width[CFG_W-1:0]);
    endtask

    task automatic run_phase(int unsigned width, int snd_pct, int rcv_pct, int items);
        set_row_width(width);
        snd_idle_pct  = snd_pct;
        rcv_stall_pct = rcv_pct;
        repeat (items) send_random_item();
        drain_pending_row();
        settle();
    endtask

    // Directed opening at width 4: reserved command and idle flush ignored,
    // a ball pixel framed by green at both ends of the sum range, a row with
    // sums just outside the range, and a row dropped after flushes.
    task automatic run_directed();
        set_row_width(4);
        send_table_write(BLACK, 1'b1);
        send_table_write(WHITE, 1'b1);
        send_table_write(GREEN_LOW, 1'b0);
        send_table_write(NEAR_LOW, 1'b1);
        send_table_write(GREEN_HIGH, 1'b1);
        send_table_write(NEAR_HIGH, 1'b0);
        palette = '{BLACK, WHITE, GREEN_LOW, NEAR_LOW, GREEN_HIGH, NEAR_HIGH};
        send_item(CMD_RSVD, WHITE, 1'b1, WHITE);
        send_flush();
        send_pixel(GREEN_LOW);
        send_pixel(WHITE);
        send_pixel(GREEN_HIGH);
        send_pixel(BLACK);
        send_pixel(NEAR_LOW);
        send_pixel(WHITE);
        send_pixel(NEAR_HIGH);
        send_pixel(BLACK);
        drain_pending_row();
        send_flush();
        settle();
    endtask

    initial begin
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_valid       <= 1'b0;
        s_cmd         <= CMD_TABLE_WR;
        s_table_index <= '0;
        s_table_flag  <= 1'b0;
        s_blue        <= '0;
        s_green       <= '0;
        s_red         <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();

        // Short rows at full rate, then width 0, which acts as one column.
        run_phase(8, 0, 0, 120);
        run_phase(0, 49, 0, 60);

        // Receiver stalls; open with a long hold-off while the sender keeps
        // offering back to back, so the block fills and stalls its input.
        set_row_width(3);
        snd_idle_pct  = 0;
        rcv_stall_pct = 49;
        hold_req      = 1'b1;
        repeat (30) send_random_item();
        repeat (120) send_random_item();
        drain_pending_row();
        settle();

        // Width above the maximum clamps to full rows of 1024 columns: one
        // row of pixels closes only at the last column, and its first
        // verdicts come out in the next phase at a narrower width.
        set_row_width(2047);
        snd_idle_pct  = 0;
        rcv_stall_pct = 23;
        repeat (MAX_W) send_pixel(palette[$urandom_range(palette.size() - 1)]);
        settle();

        // Both sides idle; pause the sender midway until all verdicts are in.
        set_row_width(13);
        snd_idle_pct  = 23;
        rcv_stall_pct = 23;
        repeat (60) send_random_item();
        settle();
        repeat (60) send_random_item();
        drain_pending_row();
        settle();

        // Leave a part row open, then shrink the width below its column so
        // the next pixel closes it.
        set_row_width(16);
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        repeat (10) send_pixel(palette[$urandom_range(palette.size() - 1)]);
        settle();
        run_phase(5, 23, 23, 100);

        run_phase(1, 49, 49, 50);
        run_phase(2, 0, 49, 60);
        run_phase(6, 0, 0, 40);

        repeat (3 * SETTLE_CYCLES) @(posedge aclk);
        if (verdict_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/bpc_pkg.sv
sv/bpc_color_table.sv
sv/bpc_mark_buffer.sv
sv/ball_pixel_on_field_classifier_top.sv
tb/ball_verdict_checker.sv
tb/testbench.sv
